FILE: hw/rtl/lpbc_pkg.sv
// Package for the LRU page buffer cache: field widths, codes and the
// request and response transaction types. No dependencies.
`default_nettype none

package lpbc_pkg;

    localparam int NUM_BUFFERS_DEF = 16;

    localparam int MODE_W       = 2;
    localparam int OFFSET_W     = 32;
    localparam int SLOT_W       = 4;
    localparam int STATUS_W     = 2;
    localparam int FLAG_W       = 2;
    localparam int PAGE_SHIFT_W = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SYNC    = 2'd2;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BUFFER  = 2'd2;

    // Buffer state flags.
    localparam logic [FLAG_W-1:0] FLAG_CLEAN  = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_DIRTY  = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_LOCKED = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_END        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK_MODE = 2'd2;

    localparam logic [PAGE_SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd10;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [OFFSET_W-1:0] page_offset;
        logic                scratch;
        logic [SLOT_W-1:0]   slot;
        logic                dirty;
    } lpbc_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   result_slot;
        logic                hit;
        logic                write_out_valid;
        logic [OFFSET_W-1:0] write_out_offset;
        logic                fill_valid;
        logic [OFFSET_W-1:0] fill_offset;
        logic                last;
    } lpbc_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lru_page_buffer_cache_core.sv
// A real acquire passes the offset check before its scan and a scratch acquire skips it; a
// release needs no scan; a sync lasts longer by any output stall. One request is in work at
// a time, and the scan, which sets the rate, visits the tag RAM read port one buffer per
// cycle while no sync write-out waits on an output stall.
// Reset is asynchronous and immediate: all buffers become clean scratch buffers in slot
// order, with no clearing pass, since tags are only read for real pages once written.
`default_nettype none

module lru_page_buffer_cache_core #(
    parameter int NUM_BUFFERS = lpbc_pkg::NUM_BUFFERS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request channel.
    input  logic                                req_valid,
    output logic                                req_stall,
    input  lpbc_pkg::lpbc_req_t                 req_item,
    // Response channel.
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output lpbc_pkg::lpbc_rsp_t                 rsp_item,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lpbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lpbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import lpbc_pkg::*;

    localparam int IDX_W = $clog2(NUM_BUFFERS);
    localparam int CNT_W = $clog2(NUM_BUFFERS + 1);
    localparam int SW    = IDX_W + SLOT_W;

    // The sequencer. A request is captured in IDLE. Real acquires first check the
    // offset. SCAN walks the recency list from least to most recent, one buffer per cycle
    // while no sync write-out stalls, with the tag read in the cycle after the list read.
    // Acquire keeps the most recent match and the least recent unlocked buffer; sync emits
    // each dirty real page as it is seen. COMMIT applies the acquire outcome, RELEASE
    // handles a release, REPLY hands a single prepared response to the output register.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_COMMIT,
        S_RELEASE,
        S_REPLY
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [PAGE_SHIFT_W-1:0] page_shift_reg, page_shift_next;
    logic [OFFSET_W-1:0]     file_end_reg, file_end_next;
    logic                    wbm_reg, wbm_next;

    // Per-buffer flags and scratch marks.
    logic [FLAG_W-1:0] flags_reg [NUM_BUFFERS];
    logic [FLAG_W-1:0] flags_next[NUM_BUFFERS];
    logic              scr_reg   [NUM_BUFFERS];
    logic              scr_next  [NUM_BUFFERS];

    // Number of dirty real pages, kept so that sync knows its final transaction.
    logic [CNT_W-1:0] num_dirty_reg, num_dirty_next;

    // Scan control.
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0] eval_slot_reg, eval_slot_next;
    logic [IDX_W-1:0] eval_pos_reg, eval_pos_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_slot_reg, hit_slot_next;
    logic [IDX_W-1:0] hit_pos_reg, hit_pos_next;
    logic             vic_found_reg, vic_found_next;
    logic [IDX_W-1:0] vic_slot_reg, vic_slot_next;
    logic [IDX_W-1:0] vic_pos_reg, vic_pos_next;
    logic             vic_dirty_reg, vic_dirty_next;
    logic [OFFSET_W-1:0] vic_tag_reg, vic_tag_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;

    // Captured request, prepared response, output register.
    lpbc_req_t req_reg, req_next;
    lpbc_rsp_t res_reg, res_next;
    logic      rsp_valid_reg, rsp_valid_next;
    lpbc_rsp_t rsp_item_reg, rsp_item_next;

    // Single-entry update of flags and scratch marks.
    logic              cm_en;
    logic [IDX_W-1:0]  cm_slot;
    logic [FLAG_W-1:0] cm_flag;
    logic              cm_scr;

    // Recency list interface.
    logic [IDX_W-1:0] ord_slot;
    logic [IDX_W-1:0] q_rank;
    logic             mv_en;
    logic             mv_lru;
    logic [IDX_W-1:0] mv_slot;
    logic [IDX_W-1:0] mv_pos;

    // Tag RAM interface.
    logic                tag_wr_en;
    logic [IDX_W-1:0]    tag_wr_addr;
    logic [OFFSET_W-1:0] tag_wr_data;
    logic [IDX_W-1:0]    tag_rd_addr;
    logic [OFFSET_W-1:0] tag_rd_data;

    // Release slot decode.
    logic [SW-1:0]    rel_slot_wide;
    logic             rel_in_range;
    logic [IDX_W-1:0] rel_idx;

    logic push_free;

    function automatic logic [SLOT_W-1:0] to_res_slot(input logic [IDX_W-1:0] s);
        logic [SW-1:0] w;
        w = {{SLOT_W{1'b0}}, s};
        return w[SLOT_W-1:0];
    endfunction

    assign rel_slot_wide = {{IDX_W{1'b0}}, req_reg.slot};
    assign rel_in_range  = rel_slot_wide < SW'(NUM_BUFFERS);
    assign rel_idx       = rel_slot_wide[IDX_W-1:0];

    // The output register can take a new transaction when it is empty or drains now.
    assign push_free = !rsp_valid_reg || !rsp_stall;

    lpbc_recency #(
        .NUM_BUFFERS(NUM_BUFFERS)
    ) u_recency (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_pos  (pos_reg[IDX_W-1:0]),
        .rd_slot (ord_slot),
        .q_slot  (rel_idx),
        .q_rank  (q_rank),
        .mv_en   (mv_en),
        .mv_lru  (mv_lru),
        .mv_slot (mv_slot),
        .mv_pos  (mv_pos)
    );

    lpbc_ram #(
        .WIDTH(OFFSET_W),
        .DEPTH(NUM_BUFFERS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (tag_wr_addr),
        .wr_data (tag_wr_data),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rd_data)
    );

    always_comb
    begin
        lpbc_rsp_t         r;
        logic [OFFSET_W-1:0] align_mask;
        logic [FLAG_W-1:0] e_flag;
        logic              e_scr;
        logic              e_unlocked;
        logic              e_match;
        logic              e_dirty_real;
        logic              is_sync;
        logic              advance;
        logic [FLAG_W-1:0] nf;

        state_next      = state_reg;
        page_shift_next = page_shift_reg;
        file_end_next   = file_end_reg;
        wbm_next        = wbm_reg;
        pos_next        = pos_reg;
        eval_valid_next = eval_valid_reg;
        eval_slot_next  = eval_slot_reg;
        eval_pos_next   = eval_pos_reg;
        hit_found_next  = hit_found_reg;
        hit_slot_next   = hit_slot_reg;
        hit_pos_next    = hit_pos_reg;
        vic_found_next  = vic_found_reg;
        vic_slot_next   = vic_slot_reg;
        vic_pos_next    = vic_pos_reg;
        vic_dirty_next  = vic_dirty_reg;
        vic_tag_next    = vic_tag_reg;
        emit_cnt_next   = emit_cnt_reg;
        req_next        = req_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_item_next   = rsp_item_reg;

        cm_en       = 1'b0;
        cm_slot     = rel_idx;
        cm_flag     = FLAG_CLEAN;
        cm_scr      = 1'b0;
        mv_en       = 1'b0;
        mv_lru      = 1'b0;
        mv_slot     = rel_idx;
        mv_pos      = q_rank;
        tag_wr_en   = 1'b0;
        tag_wr_addr = rel_idx;
        tag_wr_data = req_reg.page_offset;
        tag_rd_addr = ord_slot;

        r          = '0;
        r.last     = 1'b1;
        align_mask = ~({OFFSET_W{1'b1}} << page_shift_reg);
        e_flag       = flags_reg[eval_slot_reg];
        e_scr        = scr_reg[eval_slot_reg];
        e_unlocked   = e_flag != FLAG_LOCKED;
        e_dirty_real = !e_scr && (e_flag == FLAG_DIRTY);
        e_match      = req_reg.scratch ? e_scr
                                       : (!e_scr && (tag_rd_data == req_reg.page_offset));
        is_sync      = req_reg.mode == MODE_SYNC;
        advance      = !(eval_valid_reg && is_sync && e_dirty_real && !push_free);
        nf           = FLAG_CLEAN;

        // The user must write configuration only while the block is idle; the block does not enforce it.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PAGE_SHIFT:      page_shift_next = cfg_data[PAGE_SHIFT_W-1:0];
                CFG_FILE_END:        file_end_next   = cfg_data[OFFSET_W-1:0];
                CFG_WRITE_BACK_MODE: wbm_next        = cfg_data[0];
                default:             ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next       = req_item;
                    pos_next       = '0;
                    eval_valid_next = 1'b0;
                    hit_found_next = 1'b0;
                    vic_found_next = 1'b0;
                    emit_cnt_next  = '0;
                    unique case (req_item.mode)
                        MODE_ACQUIRE:
                        begin
                            state_next = req_item.scratch ? S_SCAN : S_CHECK;
                        end
                        MODE_RELEASE:
                        begin
                            state_next = S_RELEASE;
                        end
                        MODE_SYNC:
                        begin
                            if (num_dirty_reg == '0)
                            begin
                                res_next   = r;
                                state_next = S_REPLY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next   = r;
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                if ((req_reg.page_offset == '0) || (req_reg.page_offset >= file_end_reg)
                    || ((req_reg.page_offset & align_mask) != '0))
                begin
                    r.status   = ST_BAD_OFFSET;
                    res_next   = r;
                    state_next = S_REPLY;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (eval_valid_reg)
                begin
                    if (is_sync)
                    begin
                        if (e_dirty_real && push_free)
                        begin
                            r.result_slot      = to_res_slot(eval_slot_reg);
                            r.write_out_valid  = 1'b1;
                            r.write_out_offset = tag_rd_data;
                            r.last = (emit_cnt_reg + CNT_W'(1)) == num_dirty_reg;
                            rsp_valid_next     = 1'b1;
                            rsp_item_next      = r;
                            emit_cnt_next      = emit_cnt_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        // Later matches are more recent, so the last one wins.
                        if (e_unlocked && e_match)
                        begin
                            hit_found_next = 1'b1;
                            hit_slot_next  = eval_slot_reg;
                            hit_pos_next   = eval_pos_reg;
                        end
                        if (e_unlocked && !vic_found_reg)
                        begin
                            vic_found_next = 1'b1;
                            vic_slot_next  = eval_slot_reg;
                            vic_pos_next   = eval_pos_reg;
                            vic_dirty_next = e_dirty_real;
                            vic_tag_next   = tag_rd_data;
                        end
                    end
                end

                if (advance)
                begin
                    if (pos_reg < CNT_W'(NUM_BUFFERS))
                    begin
                        tag_rd_addr     = ord_slot;
                        eval_valid_next = 1'b1;
                        eval_slot_next  = ord_slot;
                        eval_pos_next   = pos_reg[IDX_W-1:0];
                        pos_next        = pos_reg + CNT_W'(1);
                    end
                    else
                    begin
                        eval_valid_next = 1'b0;
                        if (!eval_valid_reg)
                        begin
                            state_next = is_sync ? S_IDLE : S_COMMIT;
                        end
                    end
                end
                else
                begin
                    // Hold the tag read so the stalled entry sees the same data.
                    tag_rd_addr = eval_slot_reg;
                end
            end

            S_COMMIT:
            begin
                if (hit_found_reg)
                begin
                    r.result_slot = to_res_slot(hit_slot_reg);
                    r.hit         = 1'b1;
                    mv_en         = 1'b1;
                    mv_slot       = hit_slot_reg;
                    mv_pos        = hit_pos_reg;
                    if (req_reg.scratch)
                    begin
                        cm_en   = 1'b1;
                        cm_slot = hit_slot_reg;
                        cm_flag = FLAG_LOCKED;
                        cm_scr  = 1'b1;
                        mv_lru  = 1'b1;
                    end
                end
                else if (!vic_found_reg)
                begin
                    r.status = ST_NO_BUFFER;
                end
                else
                begin
                    r.result_slot      = to_res_slot(vic_slot_reg);
                    r.write_out_valid  = vic_dirty_reg;
                    r.write_out_offset = vic_dirty_reg ? vic_tag_reg : '0;
                    cm_en   = 1'b1;
                    cm_slot = vic_slot_reg;
                    mv_en   = 1'b1;
                    mv_slot = vic_slot_reg;
                    mv_pos  = vic_pos_reg;
                    if (req_reg.scratch)
                    begin
                        cm_flag = FLAG_LOCKED;
                        cm_scr  = 1'b1;
                        mv_lru  = 1'b1;
                    end
                    else
                    begin
                        r.fill_valid  = 1'b1;
                        r.fill_offset = req_reg.page_offset;
                        cm_flag       = FLAG_CLEAN;
                        cm_scr        = 1'b0;
                        tag_wr_en     = 1'b1;
                        tag_wr_addr   = vic_slot_reg;
                    end
                end
                res_next   = r;
                state_next = S_REPLY;
            end

            S_RELEASE:
            begin
                r.result_slot = req_reg.slot;
                if (rel_in_range)
                begin
                    cm_en   = 1'b1;
                    mv_en   = 1'b1;
                    if (req_reg.scratch)
                    begin
                        cm_flag = FLAG_CLEAN;
                        cm_scr  = 1'b1;
                        mv_lru  = 1'b1;
                    end
                    else
                    begin
                        if (req_reg.dirty)
                        begin
                            nf = FLAG_DIRTY;
                        end
                        else if (flags_reg[rel_idx] == FLAG_LOCKED)
                        begin
                            nf = FLAG_CLEAN;
                        end
                        else
                        begin
                            nf = flags_reg[rel_idx];
                        end
                        // Write-through: report the page and keep the buffer clean.
                        if (!wbm_reg && (nf == FLAG_DIRTY))
                        begin
                            r.write_out_valid  = 1'b1;
                            r.write_out_offset = req_reg.page_offset;
                            nf                 = FLAG_CLEAN;
                        end
                        cm_flag   = nf;
                        cm_scr    = 1'b0;
                        tag_wr_en = 1'b1;
                    end
                end
                res_next   = r;
                state_next = S_REPLY;
            end

            S_REPLY:
            begin
                if (push_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_item_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Flag update and dirty page count.
    always_comb
    begin
        logic old_dirty;
        logic new_dirty;

        old_dirty = !scr_reg[cm_slot] && (flags_reg[cm_slot] == FLAG_DIRTY);
        new_dirty = !cm_scr && (cm_flag == FLAG_DIRTY);

        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            flags_next[i] = flags_reg[i];
            scr_next[i]   = scr_reg[i];
            if (cm_en && (IDX_W'(i) == cm_slot))
            begin
                flags_next[i] = cm_flag;
                scr_next[i]   = cm_scr;
            end
        end

        num_dirty_next = num_dirty_reg;
        if (cm_en && old_dirty && !new_dirty)
        begin
            num_dirty_next = num_dirty_reg - CNT_W'(1);
        end
        else if (cm_en && !old_dirty && new_dirty)
        begin
            num_dirty_next = num_dirty_reg + CNT_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            page_shift_reg <= PAGE_SHIFT_RST;
            file_end_reg   <= '0;
            wbm_reg        <= 1'b0;
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                flags_reg[i] <= FLAG_CLEAN;
                scr_reg[i]   <= 1'b1;
            end
            num_dirty_reg  <= '0;
            pos_reg        <= '0;
            eval_valid_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            vic_found_reg  <= 1'b0;
            emit_cnt_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            page_shift_reg <= page_shift_next;
            file_end_reg   <= file_end_next;
            wbm_reg        <= wbm_next;
            flags_reg      <= flags_next;
            scr_reg        <= scr_next;
            num_dirty_reg  <= num_dirty_next;
            pos_reg        <= pos_next;
            eval_valid_reg <= eval_valid_next;
            hit_found_reg  <= hit_found_next;
            vic_found_reg  <= vic_found_next;
            emit_cnt_reg   <= emit_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        eval_slot_reg <= eval_slot_next;
        eval_pos_reg  <= eval_pos_next;
        hit_slot_reg  <= hit_slot_next;
        hit_pos_reg   <= hit_pos_next;
        vic_slot_reg  <= vic_slot_next;
        vic_pos_reg   <= vic_pos_next;
        vic_dirty_reg <= vic_dirty_next;
        vic_tag_reg   <= vic_tag_next;
        rsp_item_reg  <= rsp_item_next;
    end

    // One request at a time: a new transaction is taken only in IDLE.
    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: hw/rtl/lpbc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module lpbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lpbc_recency.sv
// Recency order of the buffers: a position-to-slot list and a slot-to-rank map,
// both updated by one move to either end per cycle. Depends on lpbc_pkg.
`default_nettype none

module lpbc_recency #(
    parameter int NUM_BUFFERS = lpbc_pkg::NUM_BUFFERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(NUM_BUFFERS)-1:0] rd_pos,
    output logic [$clog2(NUM_BUFFERS)-1:0] rd_slot,
    input  logic [$clog2(NUM_BUFFERS)-1:0] q_slot,
    output logic [$clog2(NUM_BUFFERS)-1:0] q_rank,
    input  logic                           mv_en,
    input  logic                           mv_lru,
    input  logic [$clog2(NUM_BUFFERS)-1:0] mv_slot,
    input  logic [$clog2(NUM_BUFFERS)-1:0] mv_pos
);

    import lpbc_pkg::*;

    localparam int IDX_W = $clog2(NUM_BUFFERS);

    logic [IDX_W-1:0] ord_reg  [NUM_BUFFERS];
    logic [IDX_W-1:0] ord_next [NUM_BUFFERS];
    logic [IDX_W-1:0] rank_reg [NUM_BUFFERS];
    logic [IDX_W-1:0] rank_next[NUM_BUFFERS];
    logic [IDX_W-1:0] lo_src   [NUM_BUFFERS];
    logic [IDX_W-1:0] hi_src   [NUM_BUFFERS];

    // Source of each position when the list shifts toward the MRU end (lo_src)
    // or toward the LRU end (hi_src); the moved slot enters at the far end.
    for (genvar q = 0; q < NUM_BUFFERS; q++)
    begin : g_src
        if (q == 0)
        begin : g_first
            assign lo_src[q] = mv_slot;
        end
        else
        begin : g_lo
            assign lo_src[q] = ord_reg[q-1];
        end
        if (q == NUM_BUFFERS - 1)
        begin : g_last
            assign hi_src[q] = mv_slot;
        end
        else
        begin : g_hi
            assign hi_src[q] = ord_reg[q+1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            ord_next[i]  = ord_reg[i];
            rank_next[i] = rank_reg[i];
            if (mv_en)
            begin
                if (mv_lru && (IDX_W'(i) <= mv_pos))
                begin
                    ord_next[i] = lo_src[i];
                end
                if (!mv_lru && (IDX_W'(i) >= mv_pos))
                begin
                    ord_next[i] = hi_src[i];
                end
                if (IDX_W'(i) == mv_slot)
                begin
                    rank_next[i] = mv_lru ? '0 : IDX_W'(NUM_BUFFERS - 1);
                end
                else if (mv_lru && (rank_reg[i] < mv_pos))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
                else if (!mv_lru && (rank_reg[i] > mv_pos))
                begin
                    rank_next[i] = rank_reg[i] - IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                ord_reg[i]  <= IDX_W'(i);
                rank_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            ord_reg  <= ord_next;
            rank_reg <= rank_next;
        end
    end

    assign rd_slot = ord_reg[rd_pos];
    assign q_rank  = rank_reg[q_slot];

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for lru_page_buffer_cache_core: acquire, release and sync
// transactions are checked against a predictor of the buffer cache kept in this file.
// Depends on lpbc_pkg and the core module only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpbc_pkg::*;

    localparam int NUM_BUFFERS = NUM_BUFFERS_DEF;
    localparam int CLK_PERIOD  = 20;

    // The mode field has one code that the package leaves unnamed; the core answers it
    // with a single empty response.
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    // The slowest stretch without any accepted transaction is one request gap, the scan
    // of an acquire and one response stall, plus the settling pauses between phases. The
    // limit is many times that.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;

    logic      req_valid = 1'b0;
    logic      req_stall;
    lpbc_req_t req_item  = '0;

    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    lpbc_rsp_t rsp_item;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    lru_page_buffer_cache_core #(
        .NUM_BUFFERS(NUM_BUFFERS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Handshake strobes. They are read right at the rising edge, before any
    // nonblocking update of that edge lands, so they show what the core sampled.
    wire req_fire = req_valid && !req_stall;
    wire rsp_fire = rsp_valid && !rsp_stall;
    wire cfg_fire = cfg_valid && cfg_ready;

    // ------------------------------------------------------------------------
    // Predicted cache state and register copies.
    // ------------------------------------------------------------------------
    logic [OFFSET_W-1:0]     buf_tag     [NUM_BUFFERS];
    logic                    buf_scratch [NUM_BUFFERS];
    logic [FLAG_W-1:0]       buf_flag    [NUM_BUFFERS];
    logic [SLOT_W-1:0]       buf_rank    [NUM_BUFFERS];

    logic [PAGE_SHIFT_W-1:0] cfg_page_shift = PAGE_SHIFT_RST;
    logic [OFFSET_W-1:0]     cfg_file_end   = '0;
    logic                    cfg_write_back = 1'b0;

    // Request transactions waiting to be driven, and responses the cache is predicted
    // to give, oldest first.
    lpbc_req_t cache_req_q [$];
    lpbc_rsp_t cache_rsp_q [$];

    int unsigned req_idle_max = 12;
    int unsigned rsp_idle_max = 12;
    int unsigned req_gap      = 0;
    int unsigned rsp_hold     = 0;
    int unsigned mismatch_cnt = 0;

    initial
    begin
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            buf_tag[i]     = '0;
            buf_scratch[i] = 1'b1;
            buf_flag[i]    = FLAG_CLEAN;
            buf_rank[i]    = i[SLOT_W-1:0];
        end
    end

    // Rank 0 is the least recent buffer, NUM_BUFFERS-1 the most recent.
    function automatic int slot_at_rank(int rank);
        for (int i = 0; i < NUM_BUFFERS; i++)
            if (int'(buf_rank[i]) == rank)
                return i;
        return 0;
    endfunction

    function automatic void rank_to_mru(int s);
        logic [SLOT_W-1:0] r;
        r = buf_rank[s];
        for (int i = 0; i < NUM_BUFFERS; i++)
            if (buf_rank[i] > r)
                buf_rank[i]--;
        buf_rank[s] = SLOT_W'(NUM_BUFFERS - 1);
    endfunction

    function automatic void rank_to_lru(int s);
        logic [SLOT_W-1:0] r;
        r = buf_rank[s];
        for (int i = 0; i < NUM_BUFFERS; i++)
            if (buf_rank[i] < r)
                buf_rank[i]++;
        buf_rank[s] = '0;
    endfunction

    function automatic void predict_acquire(lpbc_req_t r);
        lpbc_rsp_t           e;
        logic [OFFSET_W-1:0] mask;
        int                  s;
        int                  rank;
        bit                  found;
        e      = '0;
        e.last = 1'b1;
        s      = 0;
        // Real pages must be nonzero, below the file end and aligned to the page size.
        if (!r.scratch)
        begin
            mask = (32'h1 << cfg_page_shift) - 32'h1;
            if (r.page_offset == '0 || r.page_offset >= cfg_file_end ||
                (r.page_offset & mask) != '0)
            begin
                e.status = ST_BAD_OFFSET;
                cache_rsp_q.push_back(e);
                return;
            end
        end
        // Look for a hit, most recent first, skipping locked buffers.
        for (rank = NUM_BUFFERS - 1; rank >= 0; rank--)
        begin
            s = slot_at_rank(rank);
            if (buf_flag[s] == FLAG_LOCKED)
                continue;
            if (r.scratch ? buf_scratch[s]
                          : (!buf_scratch[s] && buf_tag[s] == r.page_offset))
            begin
                if (r.scratch)
                begin
                    buf_flag[s] = FLAG_LOCKED;
                    rank_to_lru(s);
                end
                else
                begin
                    rank_to_mru(s);
                end
                e.result_slot = s[SLOT_W-1:0];
                e.hit         = 1'b1;
                cache_rsp_q.push_back(e);
                return;
            end
        end
        // Miss: the victim is the least recent unlocked buffer.
        found = 1'b0;
        for (rank = 0; rank < NUM_BUFFERS && !found; rank++)
        begin
            s     = slot_at_rank(rank);
            found = (buf_flag[s] != FLAG_LOCKED);
        end
        if (!found)
        begin
            e.status = ST_NO_BUFFER;
            cache_rsp_q.push_back(e);
            return;
        end
        if (!buf_scratch[s] && buf_flag[s] == FLAG_DIRTY)
        begin
            e.write_out_valid  = 1'b1;
            e.write_out_offset = buf_tag[s];
        end
        if (!r.scratch)
        begin
            e.fill_valid   = 1'b1;
            e.fill_offset  = r.page_offset;
            buf_flag[s]    = FLAG_CLEAN;
            buf_tag[s]     = r.page_offset;
            buf_scratch[s] = 1'b0;
            rank_to_mru(s);
        end
        else
        begin
            buf_flag[s]    = FLAG_LOCKED;
            buf_tag[s]     = '0;
            buf_scratch[s] = 1'b1;
            rank_to_lru(s);
        end
        e.result_slot = s[SLOT_W-1:0];
        cache_rsp_q.push_back(e);
    endfunction

    // With sixteen buffers every slot code is in range, so release always acts.
    function automatic void predict_release(lpbc_req_t r);
        lpbc_rsp_t e;
        int        s;
        e             = '0;
        e.last        = 1'b1;
        s             = int'(r.slot);
        e.result_slot = r.slot;
        if (r.scratch)
        begin
            buf_scratch[s] = 1'b1;
            buf_tag[s]     = '0;
            buf_flag[s]    = FLAG_CLEAN;
            rank_to_lru(s);
        end
        else
        begin
            buf_scratch[s] = 1'b0;
            buf_tag[s]     = r.page_offset;
            if (r.dirty)
                buf_flag[s] = FLAG_DIRTY;
            else if (buf_flag[s] == FLAG_LOCKED)
                buf_flag[s] = FLAG_CLEAN;
            // Write-through mode pushes the dirty page out right away.
            if (!cfg_write_back && buf_flag[s] == FLAG_DIRTY)
            begin
                e.write_out_valid  = 1'b1;
                e.write_out_offset = r.page_offset;
                buf_flag[s]        = FLAG_CLEAN;
            end
            rank_to_mru(s);
        end
        cache_rsp_q.push_back(e);
    endfunction

    // Sync reports dirty real pages least recent first and leaves them dirty.
    function automatic void predict_sync();
        lpbc_rsp_t e;
        int        s;
        int        total;
        int        k;
        total = 0;
        k     = 0;
        for (int rank = 0; rank < NUM_BUFFERS; rank++)
        begin
            s = slot_at_rank(rank);
            if (!buf_scratch[s] && buf_flag[s] == FLAG_DIRTY)
                total++;
        end
        if (total == 0)
        begin
            e      = '0;
            e.last = 1'b1;
            cache_rsp_q.push_back(e);
            return;
        end
        for (int rank = 0; rank < NUM_BUFFERS; rank++)
        begin
            s = slot_at_rank(rank);
            if (!buf_scratch[s] && buf_flag[s] == FLAG_DIRTY)
            begin
                e                  = '0;
                e.result_slot      = s[SLOT_W-1:0];
                e.write_out_valid  = 1'b1;
                e.write_out_offset = buf_tag[s];
                k++;
                e.last             = (k == total);
                cache_rsp_q.push_back(e);
            end
        end
    endfunction

    function automatic void predict_cache_rsp(lpbc_req_t r);
        lpbc_rsp_t e;
        case (r.mode)
            MODE_ACQUIRE: predict_acquire(r);
            MODE_RELEASE: predict_release(r);
            MODE_SYNC:    predict_sync();
            default:
            begin
                e      = '0;
                e.last = 1'b1;
                cache_rsp_q.push_back(e);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Response checking.
    // ------------------------------------------------------------------------
    function automatic string rsp_text(lpbc_rsp_t t);
        return $sformatf("st=%0d slot=%0d hit=%0d wv=%0d wo=%h fv=%0d fo=%h last=%0d",
                         t.status, t.result_slot, t.hit, t.write_out_valid,
                         t.write_out_offset, t.fill_valid, t.fill_offset, t.last);
    endfunction

    function automatic void check_cache_rsp(lpbc_rsp_t got);
        lpbc_rsp_t want;
        bit        bad;
        if (cache_rsp_q.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("%0t: response with none predicted: %s", $realtime, rsp_text(got));
            return;
        end
        want = cache_rsp_q.pop_front();
        bad  = (got.status           !== want.status)           ||
               (got.result_slot      !== want.result_slot)      ||
               (got.hit              !== want.hit)              ||
               (got.write_out_valid  !== want.write_out_valid)  ||
               (got.write_out_offset !== want.write_out_offset) ||
               (got.fill_valid       !== want.fill_valid)       ||
               (got.fill_offset      !== want.fill_offset)      ||
               (got.last             !== want.last);
        if (bad)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("%0t: response mismatch\n  expected %s\n  actual   %s",
                         $realtime, rsp_text(want), rsp_text(got));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Each accepted request transaction is handed to the predictor
    // at the edge that accepts it. After each request a random gap is waited out before
    // the next; valid is only ever assigned once per edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : req_driver
        if (req_fire)
            predict_cache_rsp(req_item);
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_gap != 0)
            begin
                req_gap--;
                req_valid <= 1'b0;
            end
            else if (cache_req_q.size() != 0)
            begin
                req_item  <= cache_req_q.pop_front();
                req_valid <= 1'b1;
                req_gap    = $urandom_range(0, req_idle_max);
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor. After each accepted response a stall length is drawn; the
    // stall is held while that length counts down on cycles in which a response waits.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : rsp_monitor
        if (rsp_fire)
        begin
            check_cache_rsp(rsp_item);
            rsp_hold = $urandom_range(0, rsp_idle_max);
        end
        else if (rsp_valid && rsp_hold != 0)
        begin
            rsp_hold--;
        end
        rsp_stall <= rst_n && (rsp_hold != 0);
    end

    // Watchdog: ends the run if no transaction of any kind is accepted for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || req_fire || rsp_fire || cfg_fire)
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic lpbc_req_t make_req(logic [MODE_W-1:0] mode, logic [OFFSET_W-1:0] off,
                                           logic scr, logic [SLOT_W-1:0] slot, logic dirty);
        lpbc_req_t r;
        r.mode        = mode;
        r.page_offset = off;
        r.scratch     = scr;
        r.slot        = slot;
        r.dirty       = dirty;
        return r;
    endfunction

    // A small pool of aligned pages, so that hits, renames and evictions meet often.
    function automatic logic [OFFSET_W-1:0] pool_page();
        return OFFSET_W'($urandom_range(1, 20)) << cfg_page_shift;
    endfunction

    // Mostly well-formed traffic on the page pool; a few malformed offsets and
    // reserved-mode requests are mixed in.
    function automatic lpbc_req_t rand_cache_req();
        lpbc_req_t   r;
        int unsigned pick;
        r    = make_req(MODE_ACQUIRE, $urandom(), 1'($urandom_range(0, 1)),
                        SLOT_W'($urandom_range(0, NUM_BUFFERS - 1)),
                        1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            r.scratch     = 1'b0;
            r.page_offset = pool_page();
        end
        else if (pick < 52)
        begin
            r.scratch = 1'b1;
        end
        else if (pick < 82)
        begin
            r.mode    = MODE_RELEASE;
            r.scratch = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
                r.page_offset = pool_page();
        end
        else if (pick < 92)
        begin
            r.mode = MODE_SYNC;
        end
        else if (pick < 97)
        begin
            r.scratch = 1'b0;
        end
        else
        begin
            r.mode = MODE_RESERVED;
        end
        return r;
    endfunction

    task automatic queue_random(int unsigned count);
        repeat (count) cache_req_q.push_back(rand_cache_req());
    endtask

    // Locks every buffer with scratch acquires, runs one past the end to hit the
    // no-buffer case, and then releases every slot again.
    task automatic scratch_storm();
        for (int i = 0; i <= NUM_BUFFERS; i++)
            cache_req_q.push_back(make_req(MODE_ACQUIRE, $urandom(), 1'b1,
                                           SLOT_W'($urandom_range(0, NUM_BUFFERS - 1)),
                                           1'($urandom_range(0, 1))));
        for (int i = 0; i < NUM_BUFFERS; i++)
            cache_req_q.push_back(make_req(MODE_RELEASE, pool_page(),
                                           1'($urandom_range(0, 1)),
                                           i[SLOT_W-1:0], 1'($urandom_range(0, 1))));
    endtask

    // Waits, sampling away from the active edge, until every request has been accepted
    // and every predicted response has arrived, then lets the core sit a little longer.
    task automatic settle_cache(int unsigned extra);
        do @(negedge clk);
        while (cache_req_q.size() != 0 || req_valid || cache_rsp_q.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    // Writes one register through the configuration channel and updates the copy
    // the predictor works from once the write transaction has been accepted.
    task automatic write_cache_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PAGE_SHIFT:      cfg_page_shift = val[PAGE_SHIFT_W-1:0];
            CFG_FILE_END:        cfg_file_end   = val;
            CFG_WRITE_BACK_MODE: cfg_write_back = val[0];
            default:             ;
        endcase
    endtask

    task automatic set_cache_regs(logic [PAGE_SHIFT_W-1:0] shift, logic [OFFSET_W-1:0] fend,
                                  logic wb);
        write_cache_reg(CFG_PAGE_SHIFT, CFG_DATA_W'(shift));
        write_cache_reg(CFG_FILE_END, fend);
        write_cache_reg(CFG_WRITE_BACK_MODE, CFG_DATA_W'(wb));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: with a file end of zero every real page is rejected. A zero
        // offset, an aligned page, the all-ones offset, a reserved mode and an empty sync go in.
        cache_req_q.push_back(make_req(MODE_ACQUIRE, 32'h0, 1'b0, 4'd0, 1'b0));
        cache_req_q.push_back(make_req(MODE_ACQUIRE, 32'h400, 1'b0, 4'd15, 1'b1));
        cache_req_q.push_back(make_req(MODE_ACQUIRE, 32'hFFFF_FFFF, 1'b0, 4'd7, 1'b0));
        cache_req_q.push_back(make_req(MODE_RESERVED, 32'hFFFF_FFFF, 1'b1, 4'd15, 1'b1));
        cache_req_q.push_back(make_req(MODE_SYNC, 32'h0, 1'b0, 4'd0, 1'b0));
        settle_cache(25);

        // Smallest pages, whole address range, dirty pages kept in the cache.
        set_cache_regs(5'd9, 32'hFFFF_FFFF, 1'b1);
        // A miss that fills, then a hit on the same page.
        cache_req_q.push_back(make_req(MODE_ACQUIRE, 32'h200, 1'b0, 4'd0, 1'b0));
        cache_req_q.push_back(make_req(MODE_ACQUIRE, 32'h200, 1'b0, 4'd0, 1'b0));
        // The highest aligned page, a misaligned one and one at the file end.
        cache_req_q.push_back(make_req(MODE_ACQUIRE, 32'hFFFF_FE00, 1'b0, 4'd0, 1'b0));
        cache_req_q.push_back(make_req(MODE_ACQUIRE, 32'h201, 1'b0, 4'd0, 1'b0));
        cache_req_q.push_back(make_req(MODE_ACQUIRE, 32'hFFFF_FFFF, 1'b0, 4'd0, 1'b0));
        // Two renames that leave dirty pages behind, then a sync that reports both.
        cache_req_q.push_back(make_req(MODE_RELEASE, 32'h400, 1'b0, 4'd15, 1'b1));
        cache_req_q.push_back(make_req(MODE_RELEASE, 32'h600, 1'b0, 4'd14, 1'b1));
        cache_req_q.push_back(make_req(MODE_SYNC, 32'h0, 1'b0, 4'd0, 1'b0));
        // A hit on a dirty page and a scratch acquire that finds a free scratch buffer.
        cache_req_q.push_back(make_req(MODE_ACQUIRE, 32'h400, 1'b0, 4'd0, 1'b0));
        cache_req_q.push_back(make_req(MODE_ACQUIRE, 32'h0, 1'b1, 4'd0, 1'b0));
        // Back to scratch, a clean rename, and a sync that still sees the dirty flags.
        cache_req_q.push_back(make_req(MODE_RELEASE, 32'hFFFF_FFFF, 1'b1, 4'd2, 1'b1));
        cache_req_q.push_back(make_req(MODE_RELEASE, 32'h800, 1'b0, 4'd3, 1'b0));
        cache_req_q.push_back(make_req(MODE_SYNC, 32'h0, 1'b0, 4'd0, 1'b0));
        queue_random(24);
        scratch_storm();
        settle_cache(25);

        // Largest pages, a short file and write-through, with no idling on either side.
        req_idle_max = 0;
        rsp_idle_max = 0;
        set_cache_regs(5'd16, 32'h000C_0000, 1'b0);
        queue_random(24);
        settle_cache(25);

        // Middle page size in write-back mode; only the request side idles.
        req_idle_max = 12;
        rsp_idle_max = 0;
        set_cache_regs(5'd12, 32'h8000_0000, 1'b1);
        scratch_storm();
        queue_random(24);
        settle_cache(25);

        // Write-through again over the whole range; only the response side stalls.
        req_idle_max = 0;
        rsp_idle_max = 12;
        set_cache_regs(5'd13, 32'hFFFF_FFFF, 1'b0);
        queue_random(24);

        settle_cache(40);
        if (mismatch_cnt == 0 && cache_rsp_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
